[rtl/skset_pkg.sv]
// ----------------------------------------------------------------------------
// Sorted key set package
// Operation codes, status codes and the result bundle that the sequencer
// hands to the output stage.
// ----------------------------------------------------------------------------
package skset_pkg;

    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_REMOVE = 2'd1;
    localparam logic [1:0] FUNC_SEARCH = 2'd2;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_PRESENT = 2'd1,
        ST_MISSING = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    typedef struct packed {
        logic    valid;
        status_t status;
    } skset_result_t;

endpackage

[rtl/skset_engine.sv]
// ----------------------------------------------------------------------------
// Sorted key set engine
// Holds the keys in a single-port-write, registered-read memory and runs one
// operation at a time: a linear scan for the sorted position, then a
// pipelined move of the larger keys up or down by one slot.
// ----------------------------------------------------------------------------
module skset_engine #(
    parameter  int DEPTH     = 16,
    parameter  int KEY_WIDTH = 32,
    localparam int AW        = $clog2(DEPTH),
    localparam int CW        = $clog2(DEPTH + 1)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start_i,
    input  logic [1:0]                    func_i,
    input  logic signed [KEY_WIDTH-1:0]   key_i,
    input  logic                          res_take_i,
    output logic                          idle_o,
    output skset_pkg::skset_result_t      res_o,
    output logic [CW-1:0]                 count_o
);
    import skset_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_SHIFT,
        S_REPORT
    } state_t;

    state_t                       state_reg;
    logic [1:0]                   func_reg;
    logic signed [KEY_WIDTH-1:0]  key_reg;
    logic [CW-1:0]                count_reg;
    logic [CW-1:0]                idx_reg;
    logic                         found_reg;
    logic [CW-1:0]                rem_reg;
    logic [CW-1:0]                cur_reg;
    logic [CW-1:0]                wtgt_reg;
    logic                         rd_pend_reg;
    logic                         insert_reg;
    status_t                      status_reg;

    logic signed [KEY_WIDTH-1:0]  mem [DEPTH];
    logic signed [KEY_WIDTH-1:0]  rd_data_reg;

    logic [AW-1:0]                raddr;
    logic                         we;
    logic [AW-1:0]                waddr;
    logic signed [KEY_WIDTH-1:0]  wdata;
    logic [CW-1:0]                idx_plus;
    logic                         key_lt;
    logic                         key_eq;

    assign idx_plus = idx_reg + CW'(1);
    assign key_lt   = rd_data_reg < key_reg;
    assign key_eq   = rd_data_reg == key_reg;

    always_comb begin
        raddr = '0;
        we    = 1'b0;
        waddr = wtgt_reg[AW-1:0];
        wdata = rd_data_reg;
        unique case (state_reg)
            S_SCAN: begin
                // Fetch the next slot speculatively so the scan runs one slot a cycle.
                raddr = idx_plus[AW-1:0];
            end
            S_SHIFT: begin
                raddr = cur_reg[AW-1:0];
                if (rd_pend_reg) begin
                    we = 1'b1;
                end else if (rem_reg == '0 && insert_reg) begin
                    we    = 1'b1;
                    waddr = idx_reg[AW-1:0];
                    wdata = key_reg;
                end
            end
            default: begin
                raddr = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rd_data_reg <= mem[raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            rd_pend_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (start_i) begin
                        func_reg  <= func_i;
                        key_reg   <= key_i;
                        idx_reg   <= '0;
                        found_reg <= 1'b0;
                        if (count_reg == '0) begin
                            state_reg <= S_DECIDE;
                        end else begin
                            state_reg <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (key_lt) begin
                        idx_reg <= idx_plus;
                        if (idx_plus >= count_reg) begin
                            found_reg <= 1'b0;
                            state_reg <= S_DECIDE;
                        end
                    end else begin
                        found_reg <= key_eq;
                        state_reg <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    state_reg   <= S_REPORT;
                    rd_pend_reg <= 1'b0;
                    unique case (func_reg)
                        FUNC_INSERT: begin
                            if (found_reg) begin
                                status_reg <= ST_PRESENT;
                            end else if (count_reg == CW'(DEPTH)) begin
                                status_reg <= ST_FULL;
                            end else begin
                                status_reg <= ST_DONE;
                                count_reg  <= count_reg + CW'(1);
                                insert_reg <= 1'b1;
                                rem_reg    <= count_reg - idx_reg;
                                cur_reg    <= count_reg - CW'(1);
                                state_reg  <= S_SHIFT;
                            end
                        end
                        FUNC_REMOVE: begin
                            if (found_reg) begin
                                status_reg <= ST_DONE;
                                count_reg  <= count_reg - CW'(1);
                                insert_reg <= 1'b0;
                                rem_reg    <= count_reg - idx_reg - CW'(1);
                                cur_reg    <= idx_plus;
                                state_reg  <= S_SHIFT;
                            end else begin
                                status_reg <= ST_MISSING;
                            end
                        end
                        FUNC_SEARCH: begin
                            status_reg <= found_reg ? ST_DONE : ST_MISSING;
                        end
                        default: begin
                            status_reg <= ST_MISSING;
                        end
                    endcase
                end
                S_SHIFT: begin
                    // A key read in one cycle is written one slot over in the next.
                    if (rem_reg != '0) begin
                        rd_pend_reg <= 1'b1;
                        rem_reg     <= rem_reg - CW'(1);
                        if (insert_reg) begin
                            wtgt_reg <= cur_reg + CW'(1);
                            cur_reg  <= cur_reg - CW'(1);
                        end else begin
                            wtgt_reg <= cur_reg - CW'(1);
                            cur_reg  <= cur_reg + CW'(1);
                        end
                    end else begin
                        rd_pend_reg <= 1'b0;
                        if (!rd_pend_reg) begin
                            state_reg <= S_REPORT;
                        end
                    end
                end
                S_REPORT: begin
                    if (res_take_i) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign idle_o       = state_reg == S_IDLE;
    assign res_o.valid  = state_reg == S_REPORT;
    assign res_o.status = status_reg;
    assign count_o      = count_reg;

endmodule

[rtl/sorted_unique_key_set_unit.sv]
// ----------------------------------------------------------------------------
// Sorted unique key set unit
// Keeps up to DEPTH distinct signed keys in ascending order and serves
// insert, remove and search beats (an unused code reports missing), one result beat per input beat.
// ----------------------------------------------------------------------------
// One operation at a time. The scan reads the held keys one slot a cycle only
// until it reaches the sorted position, and the move then shifts only the keys
// above that position (and the one at it, on an insert) one slot a cycle, so
// the length of an operation grows with the keys held; the decision, the last
// write, the result hand-off and the idle state that takes the next beat add
// to it. A search, a refused insert or a failed remove skips the move.
// s_ready is high while the engine is idle, not while a finished result waits
// for the output register; a finished result moves into the output register
// when it is free, so the next beat can be taken while m_valid waits for
// m_ready. The key store powers up unwritten and needs no clearing pass; of
// the set's contents only the entry count is reset.
module sorted_unique_key_set_unit #(
    parameter  int DEPTH     = 16,
    parameter  int KEY_WIDTH = 32,
    localparam int CW        = $clog2(DEPTH + 1)
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_func,
    input  logic signed [KEY_WIDTH-1:0]  s_key,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [1:0]                   m_status,
    output logic [CW-1:0]                m_entry_count
);
    import skset_pkg::*;

    logic            idle;
    skset_result_t   res;
    logic [CW-1:0]   count;
    logic            res_take;
    logic            out_free;

    logic            m_valid_reg;
    logic [1:0]      m_status_reg;
    logic [CW-1:0]   m_count_reg;

    skset_engine #(
        .DEPTH     (DEPTH),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start_i    (s_valid && s_ready),
        .func_i     (s_func),
        .key_i      (s_key),
        .res_take_i (res_take),
        .idle_o     (idle),
        .res_o      (res),
        .count_o    (count)
    );

    assign s_ready  = idle;
    assign out_free = !m_valid_reg || m_ready;
    assign res_take = res.valid && out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_take) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_take) begin
            m_status_reg <= res.status;
            m_count_reg  <= count;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_entry_count = m_count_reg;

endmodule

[tb/sorted_unique_key_set_unit_tb.sv]
// ----------------------------------------------------------------------------
// Sorted unique key set unit testbench
// Drives insert, remove, search and unused-code beats into the key set,
// keeps its own sorted copy of the held keys to work out the status and
// entry count of every result beat, and checks each result in order. A short
// directed run covers the key extremes and the refusal cases. Random runs
// follow with sender and receiver idling, a long output stall and drains.
// ----------------------------------------------------------------------------
module sorted_unique_key_set_unit_tb;

    import skset_pkg::*;

    localparam int DEPTH   = 16;
    localparam int KEY_W   = 32;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int POOL_N  = 24;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
    localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};

    typedef struct packed {
        status_t          status;
        logic [CNT_W-1:0] count;
    } outcome_t;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic [1:0]              s_func = FUNC_SEARCH;
    logic signed [KEY_W-1:0] s_key = '0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic [1:0]              m_status;
    logic [CNT_W-1:0]        m_entry_count;

    // Our own copy of the set, kept sorted in ascending signed order.
    logic signed [KEY_W-1:0] set_keys [DEPTH];
    int                      set_size = 0;
    outcome_t                pending_outcomes [$];
    outcome_t                oldest;
    int                      error_count = 0;

    int                      send_idle_pct = 0;
    int                      recv_idle_pct = 0;
    int                      recv_hold_left = 0;
    logic signed [KEY_W-1:0] key_pool [POOL_N];

    sorted_unique_key_set_unit #(
        .DEPTH     (DEPTH),
        .KEY_WIDTH (KEY_W)
    ) uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_func        (s_func),
        .s_key         (s_key),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_entry_count (m_entry_count)
    );

    always #5 aclk = ~aclk;

    function automatic outcome_t apply_set_op(input logic [1:0] op,
                                              input logic signed [KEY_W-1:0] k);
        int       pos;
        int       i;
        bit       hit;
        outcome_t res;
        pos = 0;
        while (pos < set_size && set_keys[pos] < k)
            pos++;
        hit = (pos < set_size) && (set_keys[pos] == k);
        case (op)
            FUNC_INSERT: begin
                if (hit) begin
                    res.status = ST_PRESENT;
                end else if (set_size >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    for (i = set_size; i > pos; i--)
                        set_keys[i] = set_keys[i-1];
                    set_keys[pos] = k;
                    set_size++;
                    res.status = ST_DONE;
                end
            end
            FUNC_REMOVE: begin
                if (hit) begin
                    for (i = pos; i + 1 < set_size; i++)
                        set_keys[i] = set_keys[i+1];
                    set_size--;
                    res.status = ST_DONE;
                end else begin
                    res.status = ST_MISSING;
                end
            end
            FUNC_SEARCH: res.status = hit ? ST_DONE : ST_MISSING;
            default:     res.status = ST_MISSING;
        endcase
        res.count = set_size[CNT_W-1:0];
        return res;
    endfunction

    // The result check runs before the new input beat is predicted, so the
    // queue order matches the block's order even within one edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (pending_outcomes.size() == 0) begin
                    $error("result beat with nothing expected: status %0d entry_count %0d",
                           m_status, m_entry_count);
                    error_count++;
                end else begin
                    oldest = pending_outcomes.pop_front();
                    if (m_status !== oldest.status) begin
                        $error("status: expected %0d, actual %0d", oldest.status, m_status);
                        error_count++;
                    end
                    if (m_entry_count !== oldest.count) begin
                        $error("entry_count: expected %0d, actual %0d",
                               oldest.count, m_entry_count);
                        error_count++;
                    end
                end
            end
            if (s_valid && s_ready)
                pending_outcomes.push_back(apply_set_op(s_func, s_key));
        end
    end

    always @(negedge aclk) begin
        if (recv_hold_left > 0) begin
            recv_hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Called just after a falling edge; returns just after the falling edge
    // that follows the beat's acceptance.
    task automatic send_beat(input logic [1:0] op, input logic signed [KEY_W-1:0] k);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_func  <= op;
        s_key   <= k;
        do
            @(posedge aclk);
        while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(negedge aclk);
        @(negedge aclk);
    endtask

    function automatic logic signed [KEY_W-1:0] draw_key();
        if ($urandom_range(0, 99) < 65)
            return key_pool[$urandom_range(0, POOL_N - 1)];
        return $urandom;
    endfunction

    function automatic logic [1:0] draw_func(input bit grow);
        int r;
        r = $urandom_range(0, 99);
        if (r < (grow ? 65 : 20))
            return FUNC_INSERT;
        if (r < 80)
            return FUNC_REMOVE;
        if (r < 97)
            return FUNC_SEARCH;
        return FUNC_UNUSED;
    endfunction

    task automatic test_directed_cases();
        int i;
        send_beat(FUNC_INSERT, KEY_MIN);
        send_beat(FUNC_INSERT, KEY_MAX);
        send_beat(FUNC_INSERT, '0);
        send_beat(FUNC_INSERT, -1);
        send_beat(FUNC_INSERT, KEY_MAX);     // duplicate insert
        send_beat(FUNC_SEARCH, '0);
        send_beat(FUNC_SEARCH, 5);           // search miss
        send_beat(FUNC_REMOVE, -1);
        send_beat(FUNC_REMOVE, -1);          // remove of an absent key
        send_beat(FUNC_UNUSED, KEY_MIN);
        // Fill the table with keys of both signs between the extremes.
        for (i = 1; i <= 13; i++)
            send_beat(FUNC_INSERT, (i % 2) ? -(i * 1000) : i * 1000);
        send_beat(FUNC_INSERT, 77);          // new key into a full table
        send_beat(FUNC_INSERT, KEY_MIN);     // duplicate while full
        wait_drained();
    endtask

    task automatic test_random_ops(input int beats, input int s_pct, input int r_pct);
        int n;
        bit grow;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        grow = 1'b1;
        for (n = 0; n < beats; n++) begin
            // Swing between filling and emptying so both ends are reached.
            if (n % 60 == 0)
                grow = ~grow;
            send_beat(draw_func(grow), draw_key());
        end
        wait_drained();
    endtask

    task automatic test_output_stall();
        int n;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        recv_hold_left = 300;
        for (n = 0; n < 12; n++)
            send_beat(draw_func(1'($urandom_range(0, 1))), draw_key());
        wait_drained();
    endtask

    initial begin
        int i;
        key_pool[0] = KEY_MIN;
        key_pool[1] = KEY_MAX;
        key_pool[2] = '0;
        key_pool[3] = -1;
        for (i = 4; i < POOL_N; i++)
            key_pool[i] = (i < 12) ? $urandom_range(0, 40) - 20 : $urandom;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_directed_cases();
        test_random_ops(430, 18, 87);
        test_output_stall();
        test_random_ops(430, 87, 18);
        test_random_ops(430, 0, 0);

        wait_drained();
        repeat (2 * DEPTH + 20) @(negedge aclk);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin
        #7000000;
        $display("FAIL");
        $finish;
    end

endmodule

[sim.f]
rtl/skset_pkg.sv
rtl/skset_engine.sv
rtl/sorted_unique_key_set_unit.sv
tb/sorted_unique_key_set_unit_tb.sv
